// ===== design/dtp_pkg.sv =====
// Shared constants, types and helpers for the test pattern pixel unit.
package dtp_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int DIM_W          = 13;
	localparam int MODE_W         = 2;
	localparam int REG_IDX_W      = 2;
	localparam int LVL_W          = 4;
	localparam int NUM_STEPS      = 15;
	localparam int GRAY_W         = 8;

	localparam logic [REG_IDX_W-1:0] REG_WIDTH  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_HEIGHT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_MODE   = 2'd2;

	localparam logic [DIM_W-1:0] WIDTH_RST  = 13'd600;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 13'd800;

	localparam logic [MODE_W-1:0] MODE_BARS   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_RADIAL = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RST    = MODE_BARS;

	// per-stage load enables
	typedef struct packed {
		logic s1;
		logic s2;
		logic s3;
		logic s4;
	} dtp_adv_t;

	// thresholds are monotone, so the number of hits is the level
	function automatic logic [LVL_W-1:0] count_steps(input logic [NUM_STEPS-1:0] hits);
		logic [LVL_W-1:0] n;
		n = '0;
		for (int i = 0; i < NUM_STEPS; i++) begin
			n = n + LVL_W'(hits[i]);
		end
		return n;
	endfunction

endpackage

// ===== design/dtp_ctrl.sv =====
// Valid/ready control for the four-stage pixel pipeline.
module dtp_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output dtp_pkg::dtp_adv_t adv
);

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	// a stage loads when it is empty or its content moves on
	always_comb begin
		rdy4 = !v_s4 || out_ready;
		rdy3 = !v_s3 || rdy4;
		rdy2 = !v_s2 || rdy3;
		rdy1 = !v_s1 || rdy2;
		adv.s1 = rdy1;
		adv.s2 = rdy2;
		adv.s3 = rdy3;
		adv.s4 = rdy4;
	end

	assign in_ready  = rdy1;
	assign out_valid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	// input only blocks when every stage holds a pixel
	a_full_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (v_s1 && v_s2 && v_s3 && v_s4))
		else $error("input blocked with a bubble in the pipeline");

	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> v_s1)
		else $error("accepted pixel missing from stage 1");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !v_s3) |=> !out_valid)
		else $error("output repeated after transfer");

endmodule

// ===== design/dtp_bars.sv =====
// Stepped bar level: row compared against multiples of the band height.
module dtp_bars #(
	parameter int COORD_BITS = dtp_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  dtp_pkg::dtp_adv_t             adv,
	input  logic [COORD_BITS-1:0]         row,
	input  logic [dtp_pkg::DIM_W-1:0]     height,
	output logic [dtp_pkg::LVL_W-1:0]     level
);

	localparam int BAND_W = dtp_pkg::DIM_W - 4;
	localparam int THW    = dtp_pkg::DIM_W;
	localparam int CW     = (THW > COORD_BITS) ? THW : COORD_BITS;
	localparam int NS     = dtp_pkg::NUM_STEPS;

	logic [BAND_W-1:0]     band_d, band_s1;
	logic [COORD_BITS-1:0] row_s1, row_s2;
	logic [THW-1:0]        thr_s2 [NS];
	logic [NS-1:0]         hits_d, hits_s3;
	logic [dtp_pkg::LVL_W-1:0] level_s4;

	always_comb begin
		band_d = height[dtp_pkg::DIM_W-1:4];
		if (band_d == '0) band_d = BAND_W'(1);
	end

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			hits_d[k] = CW'(row_s2) >= CW'(thr_s2[k]);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			band_s1 <= band_d;
			row_s1  <= row;
		end
		if (adv.s2) begin
			row_s2 <= row_s1;
			for (int k = 0; k < NS; k++) begin
				thr_s2[k] <= THW'(band_s1) * THW'(k + 1);
			end
		end
		if (adv.s3) hits_s3 <= hits_d;
		if (adv.s4) level_s4 <= dtp_pkg::count_steps(hits_s3);
	end

	assign level = level_s4;

endmodule

// ===== design/dtp_radial.sv =====
// Radial level: squared half-pixel distance against k^2 times the squared radius.
module dtp_radial #(
	parameter int COORD_BITS = dtp_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  dtp_pkg::dtp_adv_t             adv,
	input  logic [COORD_BITS-1:0]         col,
	input  logic [COORD_BITS-1:0]         row,
	input  logic [dtp_pkg::DIM_W-1:0]     width,
	input  logic [dtp_pkg::DIM_W-1:0]     height,
	output logic [dtp_pkg::LVL_W-1:0]     level
);

	localparam int DXW = (((COORD_BITS + 1) > dtp_pkg::DIM_W) ?
		(COORD_BITS + 1) : dtp_pkg::DIM_W) + 1;
	localparam int SQW = 2 * DXW - 1;
	localparam int DW  = SQW + 1;
	localparam int SCW = DW + 8;
	localparam int MW  = 2 * dtp_pkg::DIM_W + 1;
	localparam int THW = MW + 8;
	localparam int CW  = (SCW > THW) ? SCW : THW;
	localparam int NS  = dtp_pkg::NUM_STEPS;

	logic [DXW-1:0] dx_d, dy_d, dx_s1, dy_s1;
	logic [2*dtp_pkg::DIM_W-1:0] wsq, hsq;
	logic [MW-1:0]  m_d, m_s1;
	logic signed [2*DXW-1:0] dxp, dyp;
	logic [SQW-1:0] dxsq_s2, dysq_s2;
	logic [THW-1:0] thr_s2 [NS];
	logic [THW-1:0] thr_s3 [NS];
	logic [SCW-1:0] scaled_s3;
	logic [NS-1:0]  hits;
	logic [dtp_pkg::LVL_W-1:0] level_s4;

	// offsets from center in half pixels, two's complement
	always_comb begin
		dx_d = DXW'({col, 1'b0}) - DXW'(width);
		dy_d = DXW'({row, 1'b0}) - DXW'(height);
		wsq  = width * width;
		hsq  = height * height;
		m_d  = MW'(wsq) + MW'(hsq);
		if (m_d < MW'(4)) m_d = MW'(4);
	end

	assign dxp = $signed(dx_s1) * $signed(dx_s1);
	assign dyp = $signed(dy_s1) * $signed(dy_s1);

	always_comb begin
		for (int k = 0; k < NS; k++) begin
			hits[k] = CW'(thr_s3[k]) <= CW'(scaled_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			dx_s1 <= dx_d;
			dy_s1 <= dy_d;
			m_s1  <= m_d;
		end
		if (adv.s2) begin
			dxsq_s2 <= dxp[SQW-1:0];
			dysq_s2 <= dyp[SQW-1:0];
			for (int k = 0; k < NS; k++) begin
				thr_s2[k] <= THW'(m_s1) * THW'((k + 1) * (k + 1));
			end
		end
		if (adv.s3) begin
			scaled_s3 <= SCW'(DW'(dxsq_s2) + DW'(dysq_s2)) * SCW'(225);
			thr_s3    <= thr_s2;
		end
		if (adv.s4) level_s4 <= dtp_pkg::count_steps(hits);
	end

	assign level = level_s4;

endmodule

// ===== design/display_test_pattern_pixel_unit.sv =====
// Top level of the test pattern pixel unit.
// An accepted pixel is registered in stages s1, s2, s3 and s4 in turn; out_valid rises once it reaches s4.
// Throughput: one pixel per cycle; a stalled output holds the pipeline without loss.
// Four register stages (offsets, squares and thresholds, scaling, compare and count) set latency.
// Reset clears all stage valid bits and loads width 600, height 800, bars mode.
module display_test_pattern_pixel_unit #(
	parameter int COORD_BITS = dtp_pkg::COORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COORD_BITS-1:0]             col,
	input  logic [COORD_BITS-1:0]             row,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [dtp_pkg::GRAY_W-1:0]        gray,
	input  logic                              cfg_we,
	input  logic [dtp_pkg::REG_IDX_W-1:0]     cfg_idx,
	input  logic [dtp_pkg::DIM_W-1:0]         cfg_data
);

	localparam int CHK_BIT = (COORD_BITS > 4) ? 4 : 0;

	dtp_pkg::dtp_adv_t adv;

	logic [dtp_pkg::DIM_W-1:0]  width_q, height_q;
	logic [dtp_pkg::MODE_W-1:0] mode_q;
	logic [dtp_pkg::MODE_W-1:0] mode_s1, mode_s2, mode_s3, mode_s4;
	logic chk_d, chk_s1, chk_s2, chk_s3, chk_s4;
	logic [dtp_pkg::LVL_W-1:0]  bar_lvl, rad_lvl;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= dtp_pkg::WIDTH_RST;
			height_q <= dtp_pkg::HEIGHT_RST;
			mode_q   <= dtp_pkg::MODE_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				dtp_pkg::REG_WIDTH:  width_q  <= cfg_data;
				dtp_pkg::REG_HEIGHT: height_q <= cfg_data;
				dtp_pkg::REG_MODE:   mode_q   <= cfg_data[dtp_pkg::MODE_W-1:0];
				default: ;
			endcase
		end
	end

	// 16-pixel checker cell parity
	assign chk_d = (COORD_BITS > 4) ? (col[CHK_BIT] ^ row[CHK_BIT]) : 1'b0;

	always_ff @(posedge clk) begin
		if (adv.s1) begin
			mode_s1 <= mode_q;
			chk_s1  <= chk_d;
		end
		if (adv.s2) begin
			mode_s2 <= mode_s1;
			chk_s2  <= chk_s1;
		end
		if (adv.s3) begin
			mode_s3 <= mode_s2;
			chk_s3  <= chk_s2;
		end
		if (adv.s4) begin
			mode_s4 <= mode_s3;
			chk_s4  <= chk_s3;
		end
	end

	dtp_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.adv       (adv)
	);

	dtp_bars #(
		.COORD_BITS (COORD_BITS)
	) u_bars (
		.clk    (clk),
		.adv    (adv),
		.row    (row),
		.height (height_q),
		.level  (bar_lvl)
	);

	dtp_radial #(
		.COORD_BITS (COORD_BITS)
	) u_radial (
		.clk    (clk),
		.adv    (adv),
		.col    (col),
		.row    (row),
		.width  (width_q),
		.height (height_q),
		.level  (rad_lvl)
	);

	// level * 17 is the level repeated in both nibbles
	always_comb begin
		case (mode_s4)
			dtp_pkg::MODE_BARS:   gray = {bar_lvl, bar_lvl};
			dtp_pkg::MODE_RADIAL: gray = {rad_lvl, rad_lvl};
			default:              gray = chk_s4 ? 8'hFF : 8'h00;
		endcase
	end

	a_gray_levels: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gray[7:4] == gray[3:0]))
		else $error("gray value is not a multiple of 17");

endmodule
